@@ design/ptbl_pkg.sv @@
`default_nettype none

package ptbl_pkg;

  // One whole token in 16.16 fixed point
  localparam logic [31:0] ONE_TOKEN = 32'h0001_0000;

  // Result codes
  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_SCHEMA = 2'd1,
    VERDICT_RATE   = 2'd2
  } verdict_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the request and read its bucket
    logic mul;      // form elapsed time times rate
    logic calc;     // refill and cap the bucket
    logic commit;   // spend, write back and load the response
  } ptbl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bypass;   // incoming request needs no bucket update
  } ptbl_sts_t;

endpackage

`default_nettype wire

@@ design/ptbl_req_if.sv @@
`default_nettype none

interface ptbl_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sender_id;
  logic [31:0] now_ticks;
  logic        schema_ok;

  modport source (output valid, sender_id, now_ticks, schema_ok, input ready);
  modport sink   (input valid, sender_id, now_ticks, schema_ok, output ready);
endinterface

`default_nettype wire

@@ design/ptbl_rsp_if.sv @@
`default_nettype none

interface ptbl_rsp_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [1:0] verdict;

  modport source (output valid, accepted, verdict, input ready);
  modport sink   (input valid, accepted, verdict, output ready);
endinterface

`default_nettype wire

@@ design/per_sender_token_bucket_limiter.sv @@
// Channel   Dir  Modport  Payload
// req_i     in   sink     sender_id[7:0], now_ticks[31:0], schema_ok
// rsp_o     out  source   accepted, verdict[1:0]
// cfg       in   -        cfg_we_i, cfg_wdata_i[23:0] (rate_per_second)
//
// A rate-checked request passes through bucket read, multiply, refill and commit.
// A schema failure or a zero rate skips the bucket and goes from capture straight to commit.
// The single-port bucket store and the 32x24 multiplier set these steps.
// Commit waits while an earlier response is not yet taken; reset clears the
// started flags, so no clearing pass is needed.
`default_nettype none

module per_sender_token_bucket_limiter
  import ptbl_pkg::*;
#(
  parameter int SENDERS   = 256,
  parameter int TICK_LOG2 = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  ptbl_req_if.sink         req_i,
  ptbl_rsp_if.source       rsp_o
);

  ptbl_cmd_t cmd;
  ptbl_sts_t sts;

  ptbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ptbl_dp #(
    .SENDERS   (SENDERS),
    .TICK_LOG2 (TICK_LOG2)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sender_id_i (req_i.sender_id),
    .now_ticks_i (req_i.now_ticks),
    .schema_ok_i (req_i.schema_ok),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .accepted_o  (rsp_o.accepted),
    .verdict_o   (rsp_o.verdict)
  );

endmodule

`default_nettype wire

@@ design/ptbl_ctrl.sv @@
`default_nettype none

module ptbl_ctrl
  import ptbl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  wire logic      rsp_ready_i,
  input  wire ptbl_sts_t sts_i,
  output ptbl_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       req_fire;
  logic       slot_free;

  assign req_ready_o = (state_q == S_IDLE);
  assign req_fire    = req_valid_i && req_ready_o;
  assign slot_free   = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o = rsp_valid_q;

  // Sequence one request through read, multiply, refill and commit, or from read straight to commit on bypass
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          cmd_o.capture = 1'b1;
          state_d       = sts_i.bypass ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        // hold until the response register is free
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          rsp_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ design/ptbl_dp.sv @@
`default_nettype none

module ptbl_dp
  import ptbl_pkg::*;
#(
  parameter int SENDERS   = 256,
  parameter int TICK_LOG2 = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic [7:0]  sender_id_i,
  input  wire logic [31:0] now_ticks_i,
  input  wire logic        schema_ok_i,
  input  wire ptbl_cmd_t   cmd_i,
  output ptbl_sts_t        sts_o,
  output logic             accepted_o,
  output logic [1:0]       verdict_o
);

  localparam int IDS       = 256;
  localparam int MEM_DEPTH = (SENDERS < IDS) ? SENDERS : IDS;
  localparam int IDX_W     = $clog2(MEM_DEPTH);
  localparam int SHIFT     = TICK_LOG2 - 8;

  logic [23:0]      rate_q;
  logic [IDX_W-1:0] idx_lut [IDS];
  logic [IDX_W-1:0] idx_in;

  logic [IDX_W-1:0] idx_q;
  logic [31:0]      now_q;
  logic             schema_ok_q;
  logic             bypass_q;
  logic             started_q;
  logic [31:0]      rd_tok_q;
  logic [31:0]      rd_time_q;

  logic [31:0]      tok_mem  [MEM_DEPTH];
  logic [31:0]      time_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] started_q_vec;

  logic [31:0]      elapsed;
  logic [55:0]      prod_q;
  logic [55:0]      shifted;
  logic [31:0]      refill;
  logic [32:0]      sum;
  logic [31:0]      cap;
  logic [31:0]      tok_q, tok_d;
  logic             has_token;
  logic [31:0]      tok_wr;

  logic             accepted_q;
  verdict_e         verdict_q;

  // Hold the rate register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  // Fold the sender id onto the bucket range
  for (genvar i = 0; i < IDS; i++) begin : g_idx
    assign idx_lut[i] = IDX_W'(i % MEM_DEPTH);
  end
  assign idx_in = idx_lut[sender_id_i];

  assign sts_o.bypass = !schema_ok_i || (rate_q == '0);

  // Latch the request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q       <= idx_in;
      now_q       <= now_ticks_i;
      schema_ok_q <= schema_ok_i;
      bypass_q    <= sts_o.bypass;
      started_q   <= started_q_vec[idx_in];
    end
  end

  // Bucket store: read on capture, write on commit unless bypassed
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_tok_q  <= tok_mem[idx_in];
      rd_time_q <= time_mem[idx_in];
    end
    if (cmd_i.commit && !bypass_q) begin
      tok_mem[idx_q]  <= tok_wr;
      time_mem[idx_q] <= now_q;
    end
  end

  // Mark buckets as started on their first rate-checked request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q_vec <= '0;
    end else if (cmd_i.commit && !bypass_q) begin
      started_q_vec[idx_q] <= 1'b1;
    end
  end

  // Multiply elapsed ticks by the rate
  assign elapsed = now_q - rd_time_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 56'(elapsed) * 56'(rate_q);
    end
  end

  // Refill, saturate and cap at capacity
  assign shifted = prod_q >> SHIFT;
  assign refill  = (|shifted[55:32]) ? '1 : shifted[31:0];
  assign sum     = {1'b0, rd_tok_q} + {1'b0, refill};
  assign cap     = {rate_q, 8'h00};

  always_comb begin
    if (!started_q) begin
      tok_d = cap;
    end else if (sum > {1'b0, cap}) begin
      tok_d = cap;
    end else begin
      tok_d = sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      tok_q <= tok_d;
    end
  end

  // Spend one token if a whole one is present
  assign has_token = |tok_q[31:16];
  assign tok_wr    = has_token ? (tok_q - ONE_TOKEN) : tok_q;

  // Load the response payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (bypass_q) begin
        accepted_q <= schema_ok_q;
        verdict_q  <= schema_ok_q ? VERDICT_OK : VERDICT_SCHEMA;
      end else begin
        accepted_q <= has_token;
        verdict_q  <= has_token ? VERDICT_OK : VERDICT_RATE;
      end
    end
  end

  assign accepted_o = accepted_q;
  assign verdict_o  = verdict_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_per_sender_token_bucket_limiter.sv @@
`default_nettype none

module tb_per_sender_token_bucket_limiter;
  import ptbl_pkg::*;

  localparam int SENDERS         = 256;
  localparam int TICK_LOG2       = 20;
  localparam int HOLD_CYCLES     = 300;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 220;

  typedef struct packed {
    logic     accepted;
    verdict_e verdict;
  } reply_t;

  // Per-sender bucket predictor and queue of replies still owed by the block
  class bucket_tracker;
    logic [23:0] rate;
    logic [31:0] tokens [SENDERS];
    logic [31:0] last_tick [SENDERS];
    bit          started [SENDERS];
    reply_t      reply_q [$];
    int          errors;

    function new();
      rate   = '0;
      errors = 0;
      foreach (started[i]) started[i] = 1'b0;
    endfunction

    function int pending();
      return reply_q.size();
    endfunction

    // Work out the reply to one accepted request and advance the bucket
    function void note_request(logic [7:0] sender, logic [31:0] stamp, logic ok);
      reply_t      want;
      int          slot;
      logic [31:0] cap;
      logic [31:0] level;
      logic [31:0] elapsed;
      logic [63:0] gain;
      logic [63:0] sum;
      slot = int'(sender) % SENDERS;
      cap  = {rate, 8'h00};
      if (!ok) begin
        want = '{1'b0, VERDICT_SCHEMA};
      end else if (rate == '0) begin
        want = '{1'b1, VERDICT_OK};
      end else begin
        if (!started[slot]) begin
          level         = cap;
          started[slot] = 1'b1;
        end else begin
          // Refill by elapsed time times rate, saturate, then cap
          elapsed = stamp - last_tick[slot];
          gain    = (64'(elapsed) * 64'(rate)) >> (TICK_LOG2 - 8);
          if (gain > 64'hFFFF_FFFF) gain = 64'hFFFF_FFFF;
          sum   = 64'(tokens[slot]) + gain;
          level = (sum > 64'(cap)) ? cap : sum[31:0];
        end
        last_tick[slot] = stamp;
        if (level < ONE_TOKEN) begin
          tokens[slot] = level;
          want         = '{1'b0, VERDICT_RATE};
        end else begin
          tokens[slot] = level - ONE_TOKEN;
          want         = '{1'b1, VERDICT_OK};
        end
      end
      reply_q.push_back(want);
    endfunction

    // Compare one reply with the oldest one owed
    function void check_reply(logic acc, logic [1:0] verd);
      reply_t want;
      if (reply_q.size() == 0) begin
        $display("%0t: reply with no request waiting: accepted %b verdict %0d",
                 $time, acc, verd);
        errors++;
        return;
      end
      want = reply_q.pop_front();
      if (acc !== want.accepted) begin
        $display("%0t: accepted mismatch: expected %b actual %b", $time,
                 want.accepted, acc);
        errors++;
      end
      if (verd !== want.verdict) begin
        $display("%0t: verdict mismatch: expected %0d actual %0d", $time,
                 want.verdict, verd);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [23:0] cfg_wdata_i;
  bit          calm = 1'b0;
  bit          hold_rsp = 1'b0;

  bucket_tracker tracker = new();

  ptbl_req_if req_if ();
  ptbl_rsp_if rsp_if ();

  per_sender_token_bucket_limiter #(
    .SENDERS  (SENDERS),
    .TICK_LOG2(TICK_LOG2)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watch both channels on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      tracker.note_request(req_if.sender_id, req_if.now_ticks, req_if.schema_ok);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      tracker.check_reply(rsp_if.accepted, rsp_if.verdict);
    end
  end

  // Mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic offer(input logic [7:0] sender, input logic [31:0] stamp,
                       input logic ok);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.sender_id <= sender;
    req_if.now_ticks <= stamp;
    req_if.schema_ok <= ok;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Stop offering and wait until every reply has come back
  task automatic wait_for_replies();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [23:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    tracker.rate = value;
  endtask

  task automatic run_directed();
    // Limiting off after reset, and a schema failure
    offer(8'd0, 32'd0, 1'b1);
    offer(8'd255, 32'hFFFF_FFFF, 1'b0);
    // Largest rate: first calls fill the bucket, wrap of the clock
    wait_for_replies();
    write_rate(24'hFF_FFFF);
    offer(8'd0, 32'd100, 1'b1);
    offer(8'd0, 32'd100, 1'b0);
    offer(8'd255, 32'hFFFF_FFFF, 1'b1);
    offer(8'd255, 32'd0, 1'b1);
    // Capacity below one whole token
    wait_for_replies();
    write_rate(24'd1);
    offer(8'd7, 32'd1000, 1'b1);
    offer(8'd7, 32'h8000_0000, 1'b1);
    // Exactly one token: spend, run dry, refill one second, go backwards
    wait_for_replies();
    write_rate(24'd256);
    offer(8'd10, 32'd5000, 1'b1);
    offer(8'd10, 32'd5000, 1'b1);
    offer(8'd10, 32'd5000 + (32'd1 << TICK_LOG2), 1'b1);
    offer(8'd10, 32'd4000, 1'b1);
    offer(8'd10, 32'd4000, 1'b1);
    // Rate lowered under what full buckets hold
    wait_for_replies();
    write_rate(24'd512);
    offer(8'd0, 32'd100, 1'b1);
    offer(8'd0, 32'd100, 1'b1);
    offer(8'd0, 32'd100, 1'b1);
    offer(8'd255, 32'd0, 1'b1);
    // Off again: unstarted buckets must stay unstarted
    wait_for_replies();
    write_rate(24'd0);
    offer(8'd10, 32'd0, 1'b1);
    offer(8'd50, 32'd0, 1'b1);
  endtask

  task automatic run_random();
    logic [31:0] now_t;
    logic [23:0] rate;
    logic [7:0]  base;
    logic [7:0]  sender;
    logic [31:0] stamp;
    logic        ok;
    int unsigned width;
    int unsigned step_max;
    int unsigned roll;
    now_t = $urandom;
    base  = 8'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       rate = 24'd1024;
        1:       rate = 24'hFF_FFFF;
        2:       rate = 24'd100;
        3:       rate = 24'd0;
        4:       rate = 24'($urandom_range(1, 24'hFF_FFFF));
        5:       rate = 24'd512;
        6:       rate = 24'($urandom_range(256, 4096));
        default: rate = 24'd1;
      endcase
      wait_for_replies();
      write_rate(rate);
      // Cap the time step at roughly half a token per call
      step_max = (rate == '0) ? 4096 : (32'h1000_0000 / 32'(rate)) / 2 + 1;
      width    = $urandom_range(1, 8);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        calm = (p == 5 && i < 110) || (p == 2 && i >= 40 && i < 100);
        // Stall the replies for a long stretch while requests keep coming
        if (p == 2 && i == 40) hold_rsp = 1'b1;
        if (i % 50 == 0) base = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          // Mostly well-formed traffic from a small group of senders
          sender = base + 8'($urandom_range(0, width - 1));
          now_t  = now_t + $urandom_range(0, step_max);
          stamp  = now_t;
          ok     = ($urandom_range(0, 19) != 0);
        end else if (roll < 93) begin
          sender = 8'($urandom);
          stamp  = $urandom;
          ok     = 1'($urandom_range(0, 1));
        end else begin
          // Step the clock backwards
          now_t  = now_t - $urandom_range(0, step_max * 4);
          sender = base;
          stamp  = now_t;
          ok     = 1'b1;
        end
        offer(sender, stamp, ok);
      end
    end
    calm = 1'b0;
  endtask

  // Reply side: random stalls, plus one long hold on request
  initial begin
    int unsigned run;
    int unsigned stall;
    rsp_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        run = $urandom_range(1, 8);
        rsp_if.ready <= 1'b1;
        repeat (run) @(posedge clk_i);
        stall = pick_gap();
        if (stall != 0) begin
          rsp_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    req_if.valid     = 1'b0;
    req_if.sender_id = '0;
    req_if.now_ticks = '0;
    req_if.schema_ok = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    wait_for_replies();
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("per_sender_token_bucket_limiter test passed");
    end else begin
      $display("per_sender_token_bucket_limiter test failed");
    end
    $finish;
  end

  // Give up if the block stops answering
  initial begin
    #2000000;
    $display("per_sender_token_bucket_limiter test failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/ptbl_pkg.sv
design/ptbl_req_if.sv
design/ptbl_rsp_if.sv
design/ptbl_ctrl.sv
design/ptbl_dp.sv
design/per_sender_token_bucket_limiter.sv
tb/sv/tb_per_sender_token_bucket_limiter.sv
